[src/cordic_pkg.sv]
package cordic_pkg;

   localparam int unsigned ITERATIONS = 14;
   localparam int unsigned TABLE_LEN  = 14;
   localparam int unsigned CELLS      = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned DATA_W     = 16;
   localparam int unsigned OP_W       = 2;

   localparam logic [OP_W-1:0] OP_SIN   = 2'd0;
   localparam logic [OP_W-1:0] OP_COS   = 2'd1;
   localparam logic [OP_W-1:0] OP_ATAN2 = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   localparam logic [DATA_W-1:0] GAIN         = 16'h26D7;
   localparam logic [DATA_W-1:0] HALF_PI      = 16'h6488;
   localparam logic [DATA_W-1:0] NEG_HALF_PI  = 16'h9B78;
   localparam logic [DATA_W-1:0] MIN_ANGLE    = 16'h8000;

   typedef struct packed {
      logic              valid;
      logic              done;
      logic              vec;
      logic [1:0]        sel;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } cell_type;

   function automatic logic [DATA_W-1:0] arc_of(input logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] arc;
      unique case (idx)
         4'd0:    arc = 16'h3243;
         4'd1:    arc = 16'h1DAC;
         4'd2:    arc = 16'h0FB6;
         4'd3:    arc = 16'h07D5;
         4'd4:    arc = 16'h03FE;
         4'd5:    arc = 16'h01FF;
         4'd6:    arc = 16'h00FF;
         4'd7:    arc = 16'h007F;
         4'd8:    arc = 16'h003F;
         4'd9:    arc = 16'h001F;
         4'd10:   arc = 16'h000F;
         4'd11:   arc = 16'h0007;
         4'd12:   arc = 16'h0003;
         4'd13:   arc = 16'h0001;
         default: arc = 16'h0000;
      endcase
      return arc;
   endfunction

endpackage

[src/cordic_req_if.sv]
interface cordic_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [cordic_pkg::OP_W-1:0]           op;
   logic signed [cordic_pkg::DATA_W-1:0]  operand_a;
   logic signed [cordic_pkg::DATA_W-1:0]  operand_b;

   modport source (output valid, output op, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input op, input operand_a, input operand_b, output ready);
endinterface

[src/cordic_rsp_if.sv]
interface cordic_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cordic_pkg::DATA_W-1:0]  result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

[src/cordic_cell.sv]
module cordic_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [cordic_pkg::IDX_W-1:0]      stage_idx,
   input  cordic_pkg::cell_type              cell_in,
   output cordic_pkg::cell_type              cell_out
);

   logic                               valid_ff;
   cordic_pkg::cell_type               data_ff;
   cordic_pkg::cell_type               data_in;
   logic [cordic_pkg::DATA_W-1:0]      xs;
   logic [cordic_pkg::DATA_W-1:0]      ys;
   logic [cordic_pkg::DATA_W-1:0]      arc;
   logic [cordic_pkg::DATA_W-1:0]      nx;
   logic [cordic_pkg::DATA_W-1:0]      ny;
   logic [cordic_pkg::DATA_W-1:0]      nz;
   logic                               dsub;

   always_comb begin
      xs   = cordic_pkg::DATA_W'($signed(cell_in.x) >>> stage_idx);
      ys   = cordic_pkg::DATA_W'($signed(cell_in.y) >>> stage_idx);
      arc  = cordic_pkg::arc_of(stage_idx);
      dsub = cell_in.vec ? cell_in.y[cordic_pkg::DATA_W-1] : ~cell_in.z[cordic_pkg::DATA_W-1];
      if (dsub) begin
         nx = cell_in.x - ys;
         ny = cell_in.y + xs;
         nz = cell_in.z - arc;
      end else begin
         nx = cell_in.x + ys;
         ny = cell_in.y - xs;
         nz = cell_in.z + arc;
      end
      data_in = cell_in;
      if (!cell_in.done) begin
         data_in.x    = nx;
         data_in.y    = ny;
         data_in.z    = nz;
         data_in.done = cell_in.vec ? (ny == '0) : (nz == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

[src/cordic_sin_cos_atan2_unit.sv]
// An accepted request word passes through each CORDIC cell in the chain and then through the
// output register, which holds its response word.
// Throughput: one word per cycle; the whole chain holds while a response word waits.
// Reset (synchronous, active high) clears the cell valid bits and the output valid.
module cordic_sin_cos_atan2_unit (
   input  logic                 clock,
   input  logic                 reset,
   cordic_req_if.sink           req_bus,
   cordic_rsp_if.source         rsp_bus
);

   localparam int unsigned N = cordic_pkg::CELLS;

   cordic_pkg::cell_type                load;
   cordic_pkg::cell_type                chain [N];
   logic                                advance;
   logic                                rsp_valid_ff;
   logic [cordic_pkg::DATA_W-1:0]       rsp_data_ff;
   logic [cordic_pkg::DATA_W-1:0]       rsp_data_in;
   logic [cordic_pkg::DATA_W-1:0]       a;
   logic [cordic_pkg::DATA_W-1:0]       b;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign a             = req_bus.operand_a;
   assign b             = req_bus.operand_b;

   always_comb begin
      load       = '0;
      load.valid = req_bus.valid;
      unique case (req_bus.op)
         cordic_pkg::OP_SIN: begin
            load.sel = cordic_pkg::SEL_Y;
            load.x   = cordic_pkg::GAIN;
            load.z   = a;
         end
         cordic_pkg::OP_COS: begin
            load.sel = cordic_pkg::SEL_X;
            load.x   = cordic_pkg::GAIN;
            load.z   = a;
         end
         cordic_pkg::OP_ATAN2: begin
            load.sel = cordic_pkg::SEL_Z;
            load.vec = 1'b1;
            load.x   = b;
            load.y   = a;
            if (b == '0) begin
               load.done = 1'b1;
               load.z    = a[cordic_pkg::DATA_W-1] ? cordic_pkg::NEG_HALF_PI
                                                   : cordic_pkg::HALF_PI;
            end else if (a == '0) begin
               load.done = 1'b1;
               load.z    = b[cordic_pkg::DATA_W-1] ? cordic_pkg::MIN_ANGLE : '0;
            end
         end
         default: begin
            load.sel  = cordic_pkg::SEL_Z;
            load.done = 1'b1;
         end
      endcase
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_idx (cordic_pkg::IDX_W'(i)),
         .cell_in   ((i == 0) ? load : chain[(i == 0) ? 0 : i - 1]),
         .cell_out  (chain[i])
      );
   end

   always_comb begin
      unique case (chain[N-1].sel)
         cordic_pkg::SEL_X: rsp_data_in = chain[N-1].x;
         cordic_pkg::SEL_Y: rsp_data_in = chain[N-1].y;
         default:           rsp_data_in = chain[N-1].z;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[N-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.result = rsp_data_ff;

   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> chain[0].valid)
      else $error("accepted word did not enter the first cell");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken while response word is stalled");

   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(chain[N-1].valid))
      else $error("response word without a word in the last cell");

   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[N-1]))
      else $error("last cell changed during a stall");

endmodule

[dv/cordic_sin_cos_atan2_unit_test.sv]
typedef struct packed {
   logic [cordic_pkg::OP_W-1:0]   op;
   logic [cordic_pkg::DATA_W-1:0] a;
   logic [cordic_pkg::DATA_W-1:0] b;
   logic [cordic_pkg::DATA_W-1:0] result;
} trig_word_type;

class trig_scoreboard;
   trig_word_type                 expected_results[$];
   int unsigned                   mismatches;
   int unsigned                   failures;
   logic [cordic_pkg::DATA_W-1:0] arc_step [14] = '{
      16'h3243, 16'h1DAC, 16'h0FB6, 16'h07D5, 16'h03FE, 16'h01FF, 16'h00FF,
      16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001
   };

   function automatic logic [15:0] shift_down(logic [15:0] v, int unsigned s);
      logic signed [15:0] sv;
      sv = v;
      return sv >>> s;
   endfunction

   function automatic logic [15:0] rotate_angle(logic [15:0] angle, bit want_cos);
      logic [15:0] x, y, z, xs, ys, nx, ny;
      x = cordic_pkg::GAIN;
      y = '0;
      z = angle;
      for (int i = 0; i < cordic_pkg::CELLS; i++) begin
         xs = shift_down(x, i);
         ys = shift_down(y, i);
         if (!z[15]) begin
            nx = x - ys;
            ny = y + xs;
            z  = z - arc_step[i];
         end else begin
            nx = x + ys;
            ny = y - xs;
            z  = z + arc_step[i];
         end
         x = nx;
         y = ny;
         if (z == '0) break;
      end
      return want_cos ? x : y;
   endfunction

   function automatic logic [15:0] vector_angle(logic [15:0] y_in, logic [15:0] x_in);
      logic [15:0] x, y, z, xs, ys, nx, ny;
      x = x_in;
      y = y_in;
      z = '0;
      if (x == '0) return y[15] ? cordic_pkg::NEG_HALF_PI : cordic_pkg::HALF_PI;
      if (y == '0) return x[15] ? cordic_pkg::MIN_ANGLE : 16'h0000;
      for (int i = 0; i < cordic_pkg::CELLS; i++) begin
         xs = shift_down(x, i);
         ys = shift_down(y, i);
         if (!y[15]) begin
            nx = x + ys;
            ny = y - xs;
            z  = z + arc_step[i];
         end else begin
            nx = x - ys;
            ny = y + xs;
            z  = z - arc_step[i];
         end
         x = nx;
         y = ny;
         if (y == '0) break;
      end
      return z;
   endfunction

   function automatic logic [15:0] cordic_result(logic [1:0] op, logic [15:0] a,
                                                 logic [15:0] b);
      case (op)
         cordic_pkg::OP_SIN:   return rotate_angle(a, 1'b0);
         cordic_pkg::OP_COS:   return rotate_angle(a, 1'b1);
         cordic_pkg::OP_ATAN2: return vector_angle(a, b);
         default:              return 16'h0000;
      endcase
   endfunction

   function void note_request(logic [1:0] op, logic [15:0] a, logic [15:0] b);
      trig_word_type w;
      w.op     = op;
      w.a      = a;
      w.b      = b;
      w.result = cordic_result(op, a, b);
      expected_results.push_back(w);
   endfunction

   function void check_result(logic [15:0] result);
      trig_word_type w;
      if (expected_results.size() == 0) begin
         failures++;
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response word: result %h", result);
         return;
      end
      w = expected_results.pop_front();
      if (result !== w.result) begin
         failures++;
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: op %0d a %h b %h expected %h actual %h",
                     w.op, w.a, w.b, w.result, result);
      end
   endfunction
endclass

module cordic_sin_cos_atan2_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   bit   calm;
   int   rsp_hold_left;

   trig_scoreboard sb;

   cordic_req_if req_bus ();
   cordic_rsp_if rsp_bus ();

   cordic_sin_cos_atan2_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom);
         2: return 16'(int'($urandom_range(0, 2 * cordic_pkg::HALF_PI))
                       - int'(cordic_pkg::HALF_PI));
         3: return 16'(int'($urandom_range(0, 511)) - 256);
         4: return 16'h0000;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               2:       return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [1:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return cordic_pkg::OP_SIN;
      if (r < 60) return cordic_pkg::OP_COS;
      if (r < 95) return cordic_pkg::OP_ATAN2;
      return cordic_pkg::OP_NONE;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b);
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op, a, b);
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   // response side: check accepted words, idle at random, hold off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_result(rsp_bus.result);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   initial begin
      sb = new();
      calm = 1'b0;
      rsp_hold_left = 0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= cordic_pkg::OP_SIN;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(cordic_pkg::OP_SIN,   16'h0000, 16'h0000);
      send_word(cordic_pkg::OP_COS,   16'h0000, 16'hFFFF);
      send_word(cordic_pkg::OP_SIN,   cordic_pkg::HALF_PI, 16'h0000);
      send_word(cordic_pkg::OP_COS,   cordic_pkg::HALF_PI, 16'h0000);
      send_word(cordic_pkg::OP_SIN,   cordic_pkg::NEG_HALF_PI, 16'h0000);
      send_word(cordic_pkg::OP_COS,   cordic_pkg::NEG_HALF_PI, 16'h7FFF);
      send_word(cordic_pkg::OP_SIN,   16'h3243, 16'h0000);
      send_word(cordic_pkg::OP_SIN,   16'h7FFF, 16'h0000);
      send_word(cordic_pkg::OP_COS,   16'h8000, 16'h8000);
      send_word(cordic_pkg::OP_SIN,   16'hFFFF, 16'h0000);
      send_word(cordic_pkg::OP_ATAN2, 16'h4000, 16'h0000);
      send_word(cordic_pkg::OP_ATAN2, 16'hC000, 16'h0000);
      send_word(cordic_pkg::OP_ATAN2, 16'h0000, 16'h0000);
      send_word(cordic_pkg::OP_ATAN2, 16'h0000, 16'h4000);
      send_word(cordic_pkg::OP_ATAN2, 16'h0000, 16'hC000);
      send_word(cordic_pkg::OP_ATAN2, 16'h4000, 16'h4000);
      send_word(cordic_pkg::OP_ATAN2, 16'h4000, 16'hC000);
      send_word(cordic_pkg::OP_ATAN2, 16'hC000, 16'hC000);
      send_word(cordic_pkg::OP_ATAN2, 16'h7FFF, 16'h7FFF);
      send_word(cordic_pkg::OP_ATAN2, 16'h8000, 16'h8000);
      send_word(cordic_pkg::OP_ATAN2, 16'h8000, 16'h0001);
      send_word(cordic_pkg::OP_NONE,  16'h7FFF, 16'h8000);
      send_word(cordic_pkg::OP_NONE,  16'h0000, 16'h0000);

      for (int n = 0; n < 1600; n++) begin
         if (n == 300) rsp_hold_left = 300;
         if (n == 600) calm = 1'b1;
         if (n == 900) calm = 1'b0;
         if (n == 1100) drain_results();
         send_word(pick_op(), pick_operand(), pick_operand());
      end

      drain_results();
      repeat (cordic_pkg::ITERATIONS + 10) @(posedge clock);
      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
